@@ src/metd_pkg.sv @@
// ----------------------------------------------------------------------------
// metd_pkg
// Shared types, codes and constants of the Manchester edge-timing decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package metd_pkg;

	localparam int unsigned MAX_BITS = 128;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned IDX_W    = 7;

	// event kinds
	localparam logic [1:0] FUNC_ARM     = 2'd0;
	localparam logic [1:0] FUNC_EDGE    = 2'd1;
	localparam logic [1:0] FUNC_SILENCE = 2'd2;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd3;

	// receive status
	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_RECV    = 2'd1;
	localparam logic [1:0] ST_OK      = 2'd2;
	localparam logic [1:0] ST_EXPIRED = 2'd3;

	// register indexes
	localparam logic [1:0] REG_ANSWER_LENGTH = 2'd0;
	localparam logic [1:0] REG_GLITCH_LIMIT  = 2'd1;
	localparam logic [1:0] REG_HALF_LIMIT    = 2'd2;
	localparam logic [1:0] REG_FULL_LIMIT    = 2'd3;

	// register reset values
	localparam logic [7:0] ANSWER_LENGTH_RST = 8'd37;
	localparam logic [7:0] GLITCH_LIMIT_RST  = 8'd15;
	localparam logic [7:0] HALF_LIMIT_RST    = 8'd48;
	localparam logic [7:0] FULL_LIMIT_RST    = 8'd80;

	typedef struct packed {
		logic [7:0] answer_length;
		logic [7:0] glitch_limit;
		logic [7:0] half_limit;
		logic [7:0] full_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       rx_status;
		logic             current_bit;
		logic             second_edge;
		logic             started;
		logic [CNT_W-1:0] bit_count;
	} dec_state_t;

	typedef struct packed {
		logic             bit_valid;
		logic             bit_value;
		logic [IDX_W-1:0] bit_index;
		logic [1:0]       status;
	} result_t;

	localparam dec_state_t DEC_STATE_RST = '{
		rx_status:   ST_IDLE,
		current_bit: 1'b1,
		second_edge: 1'b0,
		started:     1'b0,
		bit_count:   '0
	};

endpackage

`default_nettype wire

@@ src/metd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// metd_cfg_regs
// Configuration register file: length and interval limits.
// ----------------------------------------------------------------------------
`default_nettype none

module metd_cfg_regs (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  wire [1:0]           wr_index,
	input  wire [7:0]           wr_data,
	output metd_pkg::cfg_t      cfg
);

	metd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.answer_length <= metd_pkg::ANSWER_LENGTH_RST;
			cfg_q.glitch_limit  <= metd_pkg::GLITCH_LIMIT_RST;
			cfg_q.half_limit    <= metd_pkg::HALF_LIMIT_RST;
			cfg_q.full_limit    <= metd_pkg::FULL_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				metd_pkg::REG_ANSWER_LENGTH: cfg_q.answer_length <= wr_data;
				metd_pkg::REG_GLITCH_LIMIT:  cfg_q.glitch_limit  <= wr_data;
				metd_pkg::REG_HALF_LIMIT:    cfg_q.half_limit    <= wr_data;
				metd_pkg::REG_FULL_LIMIT:    cfg_q.full_limit    <= wr_data;
				default:                     cfg_q.full_limit    <= wr_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ src/metd_decode.sv @@
// ----------------------------------------------------------------------------
// metd_decode
// Next-state and result logic for one receiver event.
// ----------------------------------------------------------------------------
`default_nettype none

module metd_decode (
	input  wire metd_pkg::cfg_t       cfg,
	input  wire metd_pkg::dec_state_t cur,
	input  wire [1:0]                 func,
	input  wire [7:0]                 interval,
	output metd_pkg::dec_state_t      nxt,
	output metd_pkg::result_t         res
);

	logic [metd_pkg::CNT_W-1:0] exp_len;
	logic [metd_pkg::CNT_W-1:0] exp_len_m1;

	// clamp the expected length to 1..MAX_BITS
	always_comb begin
		if (cfg.answer_length == 8'd0) begin
			exp_len = 8'd1;
		end else if (cfg.answer_length > 8'(metd_pkg::MAX_BITS)) begin
			exp_len = 8'(metd_pkg::MAX_BITS);
		end else begin
			exp_len = cfg.answer_length;
		end
		exp_len_m1 = exp_len - 8'd1;
	end

	always_comb begin
		nxt           = cur;
		res.bit_valid = 1'b0;
		res.bit_value = 1'b0;
		res.bit_index = '0;

		if (func == metd_pkg::FUNC_ARM) begin
			nxt           = metd_pkg::DEC_STATE_RST;
			nxt.rx_status = metd_pkg::ST_RECV;
		end else if (cur.rx_status == metd_pkg::ST_RECV) begin
			unique case (func)
				metd_pkg::FUNC_EDGE: begin
					if (!cur.started) begin
						nxt.started = 1'b1;
					end else begin
						if (interval < cfg.glitch_limit) begin
							nxt           = metd_pkg::DEC_STATE_RST;
							nxt.rx_status = cur.rx_status;
						end else if (interval < cfg.half_limit) begin
							// half period: a bit on each edge that finds second_edge set
							if (cur.second_edge) begin
								res.bit_valid   = 1'b1;
								res.bit_value   = cur.current_bit;
								res.bit_index   = cur.bit_count[metd_pkg::IDX_W-1:0];
								nxt.bit_count   = cur.bit_count + 8'd1;
								nxt.second_edge = 1'b0;
							end else begin
								nxt.second_edge = 1'b1;
							end
						end else if (interval < cfg.full_limit) begin
							// full period: emit, then invert
							res.bit_valid   = 1'b1;
							res.bit_value   = cur.current_bit;
							res.bit_index   = cur.bit_count[metd_pkg::IDX_W-1:0];
							nxt.current_bit = ~cur.current_bit;
							nxt.bit_count   = cur.bit_count + 8'd1;
							nxt.second_edge = 1'b1;
						end else begin
							nxt           = metd_pkg::DEC_STATE_RST;
							nxt.rx_status = cur.rx_status;
						end
						if (nxt.bit_count == exp_len) begin
							nxt.rx_status = metd_pkg::ST_OK;
						end
					end
				end
				metd_pkg::FUNC_SILENCE: begin
					if (cur.bit_count == exp_len_m1) begin
						if (cur.second_edge) begin
							res.bit_valid = 1'b1;
							res.bit_value = cur.current_bit;
							res.bit_index = cur.bit_count[metd_pkg::IDX_W-1:0];
						end
						nxt.bit_count = cur.bit_count + 8'd1;
						nxt.rx_status = metd_pkg::ST_OK;
					end else begin
						nxt           = metd_pkg::DEC_STATE_RST;
						nxt.rx_status = cur.rx_status;
					end
				end
				default: begin
					nxt.rx_status = metd_pkg::ST_EXPIRED;
				end
			endcase
		end

		res.status = nxt.rx_status;
	end

endmodule

`default_nettype wire

@@ src/manchester_edge_timing_decoder_core.sv @@
// ----------------------------------------------------------------------------
// manchester_edge_timing_decoder_core
// Manchester reply receiver that decodes bits from edge spacing events.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid / tready        tdata: interval, tuser: func
//  m_axis    out  tvalid / tready        tdata: bit_value, bit_index, status
//                                        tuser: bit_valid
//  cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained unless m_axis stalls: an event is held in the
// input stage, the decode logic updates the receiver state and loads the
// result register that drives m_axis.
// A stall on m_axis holds the input stage until the result register drains.
// arst_n clears stage valids and receiver state and presets cfg registers.
// ----------------------------------------------------------------------------
`default_nettype none

module manchester_edge_timing_decoder_core (
	input  wire        clk,
	input  wire        arst_n,

	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [7:0]  s_axis_tdata,   // [7:0] interval
	input  wire [1:0]  s_axis_tuser,   // [1:0] func

	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [0] bit_value, [7:1] bit_index,
	                                   // [9:8] status, [15:10] zero
	output logic       m_axis_tuser,   // [0] bit_valid

	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [7:0]  cfg_data
);

	metd_pkg::cfg_t       cfg;
	metd_pkg::dec_state_t state_q;
	metd_pkg::dec_state_t state_nxt;
	metd_pkg::result_t    res;
	metd_pkg::result_t    res_s2;

	logic       valid_s1;
	logic [1:0] func_s1;
	logic [7:0] interval_s1;
	logic       valid_s2;
	logic       adv_s1;

	assign cfg_ready = 1'b1;

	metd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// advance the input stage when the result register is free or draining
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			func_s1     <= s_axis_tuser;
			interval_s1 <= s_axis_tdata;
		end
	end

	metd_decode u_decode (
		.cfg      (cfg),
		.cur      (state_q),
		.func     (func_s1),
		.interval (interval_s1),
		.nxt      (state_nxt),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= metd_pkg::DEC_STATE_RST;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.bit_valid;
	assign m_axis_tdata  = {6'd0, res_s2.status, res_s2.bit_index, res_s2.bit_value};

endmodule

`default_nettype wire
